>>> sv/pmm_pkg.sv
// ----------------------------------------------------------------------------
// pmm_pkg
// shared constants, register codes and state encoding for the pooling block
// ----------------------------------------------------------------------------
package pmm_pkg;

  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_WINDOW_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_CHANS = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_WIDTH  = 3'd0,
    REG_INPUT_HEIGHT = 3'd1,
    REG_WINDOW_WIDTH = 3'd2,
    REG_WINDOW_HEIGHT = 3'd3,
    REG_X_STRIDE     = 3'd4,
    REG_Y_STRIDE     = 3'd5,
    REG_CHANNELS     = 3'd6,
    REG_POOL_MODE    = 3'd7
  } cfg_reg_t;

  localparam logic [8:0]  RST_INPUT_WIDTH   = 9'd28;
  localparam logic [10:0] RST_INPUT_HEIGHT  = 11'd28;
  localparam logic [3:0]  RST_WINDOW_WIDTH  = 4'd2;
  localparam logic [3:0]  RST_WINDOW_HEIGHT = 4'd2;
  localparam logic [3:0]  RST_X_STRIDE      = 4'd2;
  localparam logic [3:0]  RST_Y_STRIDE      = 4'd2;
  localparam logic [10:0] RST_CHANNELS      = 11'd1;
  localparam logic        RST_POOL_MODE     = 1'b0;

  localparam logic MODE_MAX  = 1'b0;
  localparam logic MODE_MEAN = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_LAST = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

endpackage

>>> sv/pmm_line_store.sv
// ----------------------------------------------------------------------------
// pmm_line_store
// banked row memory, one bank per window row, one write and one read per bank
// ----------------------------------------------------------------------------
module pmm_line_store #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_WINDOW  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [$clog2(MAX_WINDOW)-1:0]            wr_bank,
  input  logic [$clog2(MAX_WIDTH)-1:0]             wr_addr,
  input  logic [SAMPLE_BITS-1:0]                   wr_data,
  input  logic                                     rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]             rd_addr,
  output logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]   rd_data
);
  import pmm_pkg::*;

  localparam int BANKW = $clog2(MAX_WINDOW);

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_bank
    logic [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == BANKW'(g)) begin
        mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
        rd_data[g] <= mem[rd_addr];
      end
    end
  end

endmodule

>>> sv/pmm_div.sv
// ----------------------------------------------------------------------------
// pmm_div
// signed by unsigned divider, three quotient bits per cycle, truncates to zero
// ----------------------------------------------------------------------------
module pmm_div #(
  parameter int SUMW  = 22,
  parameter int AREAW = 8,
  parameter int QW    = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUMW-1:0]  dividend,
  input  logic [AREAW-1:0]        divisor,
  output logic                    done,
  output logic [QW-1:0]           quot
);
  import pmm_pkg::*;

  localparam int STEPS = (SUMW + 2) / 3;
  localparam int DIVW  = 3 * STEPS;
  localparam int CNTW  = $clog2(STEPS + 1);
  localparam int REMW  = AREAW + 1;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic              neg_r;
  logic [DIVW-1:0]   dvd_r;
  logic [REMW-1:0]   rem_r;
  logic [AREAW-1:0]  dsr_r;
  logic [SUMW-1:0]   mag;
  logic [DIVW-1:0]   q_step;
  logic [REMW-1:0]   r_step;

  assign mag = dividend[SUMW-1] ? SUMW'(-dividend) : SUMW'(dividend);

  always_comb begin
    r_step = rem_r;
    q_step = dvd_r;
    for (int k = 0; k < 3; k++) begin
      r_step = {r_step[REMW-2:0], q_step[DIVW-1]};
      q_step = {q_step[DIVW-2:0], 1'b0};
      if (r_step >= {1'b0, dsr_r}) begin
        r_step    = r_step - {1'b0, dsr_r};
        q_step[0] = 1'b1;
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUMW-1];
      dvd_r <= DIVW'(mag);
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= q_step;
      rem_r <= r_step;
    end
  end

  assign done = done_r;
  assign quot = neg_r ? QW'(-dvd_r) : QW'(dvd_r);

endmodule

>>> sv/pool_2d_max_mean_top.sv
// ----------------------------------------------------------------------------
// pool_2d_max_mean_top
// 2-d max / mean pooling over a raster stream of channel planes
// ----------------------------------------------------------------------------
// samples enter on in_valid / in_ready in raster order, plane after plane.
// each transfer is written to a banked line store, one bank per window row.
// when a sample closes a strided window, the block walks the window one
// column a cycle, reading all row banks in parallel at that column.
// a sample that closes no window leaves the block ready for the next.
// a closing sample walks the window columns in max mode; mean mode adds
// the divider, which produces three quotient bits a cycle.
// results leave on out_valid / out_ready from an output register; the next
// sample is taken while a result waits, and a new window stalls in its
// final step until the output register frees up.
// reset (synchronous, rst_n low) loads default configuration and returns to
// the start of a frame; any configuration write also restarts the frame.
// the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module pool_2d_max_mean_top #(
  parameter int MAX_WIDTH   = pmm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW  = pmm_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = pmm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS-1:0]    out_pooled_value,
  output logic [2:0]                       out_offset_x,
  output logic [2:0]                       out_offset_y,
  output logic [7:0]                       out_col,
  output logic [9:0]                       out_row,
  output logic [9:0]                       out_channel,
  output logic                             out_frame_last
);
  import pmm_pkg::*;

  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WEFFW = COLW + 1;
  localparam int BANKW = $clog2(MAX_WINDOW);
  localparam int OFFW  = BANKW;
  localparam int WINW  = $clog2(MAX_WINDOW + 1);
  localparam int AREAW = 2 * WINW;
  localparam int SUMW  = SAMPLE_BITS + AREAW;

  // configuration registers
  logic [8:0]  reg_iw_r;
  logic [10:0] reg_ih_r;
  logic [3:0]  reg_ww_r, reg_wh_r, reg_xs_r, reg_ys_r;
  logic [10:0] reg_ch_r;
  logic        reg_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_iw_r   <= RST_INPUT_WIDTH;
      reg_ih_r   <= RST_INPUT_HEIGHT;
      reg_ww_r   <= RST_WINDOW_WIDTH;
      reg_wh_r   <= RST_WINDOW_HEIGHT;
      reg_xs_r   <= RST_X_STRIDE;
      reg_ys_r   <= RST_Y_STRIDE;
      reg_ch_r   <= RST_CHANNELS;
      reg_mode_r <= RST_POOL_MODE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_INPUT_WIDTH:   reg_iw_r   <= cfg_wdata[8:0];
        REG_INPUT_HEIGHT:  reg_ih_r   <= cfg_wdata;
        REG_WINDOW_WIDTH:  reg_ww_r   <= cfg_wdata[3:0];
        REG_WINDOW_HEIGHT: reg_wh_r   <= cfg_wdata[3:0];
        REG_X_STRIDE:      reg_xs_r   <= cfg_wdata[3:0];
        REG_Y_STRIDE:      reg_ys_r   <= cfg_wdata[3:0];
        REG_CHANNELS:      reg_ch_r   <= cfg_wdata;
        REG_POOL_MODE:     reg_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [WEFFW-1:0] w_eff;
  logic [10:0]      h_eff, ch_eff;
  logic [WINW-1:0]  ww_eff, wh_eff;
  logic [3:0]       xs_eff, ys_eff;

  always_comb begin
    if (reg_iw_r == '0)                 w_eff = WEFFW'(1);
    else if (32'(reg_iw_r) > MAX_WIDTH) w_eff = WEFFW'(MAX_WIDTH);
    else                                w_eff = WEFFW'(reg_iw_r);
    if (reg_ih_r == '0)                h_eff = 11'd1;
    else if (32'(reg_ih_r) > MAX_ROWS) h_eff = 11'(MAX_ROWS);
    else                               h_eff = reg_ih_r;
    if (reg_ch_r == '0)                 ch_eff = 11'd1;
    else if (32'(reg_ch_r) > MAX_CHANS) ch_eff = 11'(MAX_CHANS);
    else                                ch_eff = reg_ch_r;
    if (reg_ww_r == '0)                  ww_eff = WINW'(1);
    else if (32'(reg_ww_r) > MAX_WINDOW) ww_eff = WINW'(MAX_WINDOW);
    else                                 ww_eff = WINW'(reg_ww_r);
    if (reg_wh_r == '0)                  wh_eff = WINW'(1);
    else if (32'(reg_wh_r) > MAX_WINDOW) wh_eff = WINW'(MAX_WINDOW);
    else                                 wh_eff = WINW'(reg_wh_r);
    xs_eff = (reg_xs_r == '0) ? 4'd1 : reg_xs_r;
    ys_eff = (reg_ys_r == '0) ? 4'd1 : reg_ys_r;
  end

  // position tracking
  logic [COLW-1:0]  col_r, ox_r;
  logic [9:0]       row_r, chan_r, oy_r;
  logic [BANKW-1:0] slot_r;
  logic [3:0]       xph_r, yph_r;
  state_t           state_r;

  logic             accept;
  logic [WEFFW-1:0] col_p1;
  logic [10:0]      row_p1, chan_p1;
  logic             xcond, ycond, xhit, yhit, hit;
  logic             row_end, plane_end, frame_end;
  logic             last_x, last_y, last_ch;
  logic [COLW-1:0]  x0;

  assign accept    = in_valid && in_ready;
  assign col_p1    = WEFFW'(col_r) + WEFFW'(1);
  assign row_p1    = {1'b0, row_r} + 11'd1;
  assign chan_p1   = {1'b0, chan_r} + 11'd1;
  assign xcond     = 32'(col_p1) >= 32'(ww_eff);
  assign ycond     = 32'(row_p1) >= 32'(wh_eff);
  assign xhit      = xcond && (xph_r == '0);
  assign yhit      = ycond && (yph_r == '0);
  assign hit       = xhit && yhit;
  assign row_end   = col_p1 == w_eff;
  assign plane_end = row_end && (row_p1 == h_eff);
  assign frame_end = plane_end && (chan_p1 == ch_eff);
  assign last_x    = 32'(col_r) + 32'(xs_eff) >= 32'(w_eff);
  assign last_y    = 32'(row_r) + 32'(ys_eff) >= 32'(h_eff);
  assign last_ch   = chan_p1 == ch_eff;
  assign x0        = COLW'(32'(col_p1) - 32'(ww_eff));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
      slot_r <= '0;
      xph_r  <= '0;
      yph_r  <= '0;
      ox_r   <= '0;
      oy_r   <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_r <= '0;
        xph_r <= '0;
        ox_r  <= '0;
        if (plane_end) begin
          row_r  <= '0;
          yph_r  <= '0;
          oy_r   <= '0;
          slot_r <= '0;
          chan_r <= frame_end ? 10'd0 : 10'(chan_p1);
        end else begin
          row_r  <= 10'(row_p1);
          slot_r <= (32'(slot_r) == MAX_WINDOW - 1) ? '0 : slot_r + BANKW'(1);
          if (ycond) begin
            yph_r <= (yph_r == ys_eff - 4'd1) ? 4'd0 : yph_r + 4'd1;
            oy_r  <= oy_r + 10'(yhit);
          end
        end
      end else begin
        col_r <= COLW'(col_p1);
        if (xcond) begin
          xph_r <= (xph_r == xs_eff - 4'd1) ? 4'd0 : xph_r + 4'd1;
          ox_r  <= ox_r + COLW'(xhit);
        end
      end
    end
  end

  // window capture
  logic [COLW-1:0]  win_x0_r, win_ox_r;
  logic [9:0]       win_oy_r, win_chan_r;
  logic             win_last_r;
  logic [BANKW-1:0] win_slot_r;

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      win_x0_r   <= x0;
      win_ox_r   <= ox_r;
      win_oy_r   <= oy_r;
      win_chan_r <= chan_r;
      win_last_r <= last_x && last_y && last_ch;
      win_slot_r <= slot_r;
    end
  end

  // line store
  logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] rd_data;
  logic                                   rd_en;
  logic [OFFW-1:0]                        m_r;
  logic [COLW-1:0]                        rd_addr;

  assign rd_en   = state_r == S_READ;
  assign rd_addr = COLW'(32'(win_x0_r) + 32'(m_r));

  pmm_line_store #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_bank (slot_r),
    .wr_addr (col_r),
    .wr_data (in_sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // row of the window held by each bank
  logic [31:0]     bank_d [MAX_WINDOW];
  logic            bank_ok [MAX_WINDOW];
  logic [OFFW-1:0] bank_l [MAX_WINDOW];

  always_comb begin
    for (int b = 0; b < MAX_WINDOW; b++) begin
      bank_d[b]  = (32'(win_slot_r) >= 32'(b)) ? 32'(win_slot_r) - 32'(b)
                                               : 32'(win_slot_r) + 32'(MAX_WINDOW) - 32'(b);
      bank_ok[b] = bank_d[b] < 32'(wh_eff);
      bank_l[b]  = OFFW'(32'(wh_eff) - 32'd1 - bank_d[b]);
    end
  end

  // column reduction and running accumulation
  logic                          issue_d_r;
  logic [OFFW-1:0]               m_d_r;
  logic signed [SUMW-1:0]        sum_r, sum_nxt, col_sum;
  logic                          best_ok_r;
  logic signed [SAMPLE_BITS-1:0] best_r, col_v;
  logic [OFFW-1:0]               bx_r, by_r, col_l;
  logic                          col_ok, take;

  always_comb begin
    col_ok  = 1'b0;
    col_v   = '0;
    col_l   = '0;
    col_sum = '0;
    for (int b = 0; b < MAX_WINDOW; b++) begin
      if (bank_ok[b]) begin
        col_sum = col_sum + SUMW'(signed'(rd_data[b]));
        if (!col_ok || signed'(rd_data[b]) > col_v ||
            (signed'(rd_data[b]) == col_v && bank_l[b] < col_l)) begin
          col_ok = 1'b1;
          col_v  = signed'(rd_data[b]);
          col_l  = bank_l[b];
        end
      end
    end
    sum_nxt = sum_r + col_sum;
    take    = !best_ok_r || col_v > best_r || (col_v == best_r && col_l < by_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_ok_r <= 1'b0;
      issue_d_r <= 1'b0;
    end else begin
      issue_d_r <= rd_en;
      if (accept && hit) begin
        best_ok_r <= 1'b0;
      end else if (issue_d_r) begin
        best_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_d_r <= m_r;
    if (accept && hit) begin
      sum_r <= '0;
    end else if (issue_d_r) begin
      sum_r <= sum_nxt;
      if (take) begin
        best_r <= col_v;
        bx_r   <= m_d_r;
        by_r   <= col_l;
      end
    end
  end

  // mean divider
  logic                   div_start, div_done;
  logic [SAMPLE_BITS-1:0] div_quot;

  assign div_start = (state_r == S_LAST) && (reg_mode_r == MODE_MEAN);

  pmm_div #(
    .SUMW  (SUMW),
    .AREAW (AREAW),
    .QW    (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (AREAW'(ww_eff) * AREAW'(wh_eff)),
    .done     (div_done),
    .quot     (div_quot)
  );

  // sequencer
  state_t state_nxt;
  logic   out_load;

  assign out_load = (state_r == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && hit) state_nxt = S_READ;
      S_READ: if (32'(m_r) == 32'(ww_eff) - 32'd1) state_nxt = S_LAST;
      S_LAST: state_nxt = (reg_mode_r == MODE_MEAN) ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      m_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_READ) begin
        m_r <= m_r + OFFW'(1);
      end else begin
        m_r <= '0;
      end
    end
  end

  assign in_ready = state_r == S_IDLE;

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (reg_mode_r == MODE_MEAN) begin
        out_pooled_value <= signed'(div_quot);
        out_offset_x     <= '0;
        out_offset_y     <= '0;
      end else begin
        out_pooled_value <= best_r;
        out_offset_x     <= 3'(bx_r);
        out_offset_y     <= 3'(by_r);
      end
      out_col        <= 8'(win_ox_r);
      out_row        <= win_oy_r;
      out_channel    <= win_chan_r;
      out_frame_last <= win_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/pmm_checker.sv
// ----------------------------------------------------------------------------
// pmm_checker
// port level checks on the pooling block result channel
// ----------------------------------------------------------------------------
module pmm_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_pooled_value,
  input logic [2:0]             out_offset_x,
  input logic [2:0]             out_offset_y
);
  import pmm_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value and position
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pooled_value) &&
      $stable(out_offset_x) && $stable(out_offset_y))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a window walk always separates an input transfer from its result
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result right after input transfer");

endmodule

bind pool_2d_max_mean_top pmm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_pmm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_pooled_value (out_pooled_value),
  .out_offset_x     (out_offset_x),
  .out_offset_y     (out_offset_y)
);

>>> tb/pool_2d_max_mean_top_tb.sv
// ----------------------------------------------------------------------------
// pool_2d_max_mean_top_tb
// checks pool_2d_max_mean_top against its own pooling predictor: a directed
// table of small planes with hand-read results, then randomly sized frames
// with random samples, random gaps on both channels and one long output stall
// ----------------------------------------------------------------------------
module pool_2d_max_mean_top_tb;
  import pmm_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         ox;
    logic [2:0]         oy;
    logic [7:0]         col;
    logic [9:0]         row;
    logic [9:0]         chan;
    logic               last;
  } pooled_t;

  typedef struct {
    int                 phase;
    logic signed [15:0] sample;
    bit                 typed;
    logic signed [15:0] value;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [15:0]    in_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [15:0]    out_pooled_value;
  logic [2:0]            out_offset_x, out_offset_y;
  logic [7:0]            out_col;
  logic [9:0]            out_row, out_channel;
  logic                  out_frame_last;

  // predictor copy of registers, line store and position
  logic [10:0] pool_regs [0:7];
  int          line_store [0:2047];
  int          col_pos, row_pos, chan_pos;
  pooled_t     pending_pools[$];
  int          errors = 0;
  int          hold_cycles = 0;

  pool_2d_max_mean_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .out_valid(out_valid), .out_ready(out_ready),
    .out_pooled_value(out_pooled_value), .out_offset_x(out_offset_x),
    .out_offset_y(out_offset_y), .out_col(out_col), .out_row(out_row),
    .out_channel(out_channel), .out_frame_last(out_frame_last)
  );

  always #5 clk = ~clk;

  function automatic int eff(cfg_reg_t idx, int hi);
    int v;
    v = pool_regs[idx];
    if (v == 0) v = 1;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic pool_step(input logic signed [15:0] s, output bit got, output pooled_t r);
    int w, h, ww, wh, xs, ys, ch, x0, y0, best, v, bx, by;
    longint sum;
    w  = eff(REG_INPUT_WIDTH, 256);
    h  = eff(REG_INPUT_HEIGHT, MAX_ROWS);
    ww = eff(REG_WINDOW_WIDTH, 8);
    wh = eff(REG_WINDOW_HEIGHT, 8);
    xs = eff(REG_X_STRIDE, 15);
    ys = eff(REG_Y_STRIDE, 15);
    ch = eff(REG_CHANNELS, MAX_CHANS);
    got = 0;
    r = '0;
    if (col_pos >= w || row_pos >= h || chan_pos >= ch) begin
      col_pos = 0; row_pos = 0; chan_pos = 0;
    end
    line_store[(row_pos % 8) * 256 + col_pos] = s;
    if (col_pos + 1 >= ww && row_pos + 1 >= wh &&
        (col_pos + 1 - ww) % xs == 0 && (row_pos + 1 - wh) % ys == 0) begin
      x0 = col_pos + 1 - ww;
      y0 = row_pos + 1 - wh;
      sum = 0; bx = 0; by = 0;
      best = line_store[(y0 % 8) * 256 + x0];
      for (int l = 0; l < wh; l++)
        for (int m = 0; m < ww; m++) begin
          v = line_store[((y0 + l) % 8) * 256 + x0 + m];
          sum += v;
          if (v > best) begin
            best = v; bx = m; by = l;
          end
        end
      if (pool_regs[REG_POOL_MODE][0] == MODE_MEAN) begin
        r.value = 16'(sum / (ww * wh));
        bx = 0; by = 0;
      end else begin
        r.value = 16'(best);
      end
      r.ox = 3'(bx);
      r.oy = 3'(by);
      r.col = 8'(x0 / xs);
      r.row = 10'(y0 / ys);
      r.chan = 10'(chan_pos);
      r.last = (x0 / xs == (w - ww) / xs) && (y0 / ys == (h - wh) / ys) &&
               (chan_pos + 1 == ch);
      got = 1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        chan_pos++;
        if (chan_pos >= ch) chan_pos = 0;
      end
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_sample(input logic signed [15:0] s, input bit typed,
                             input logic signed [15:0] typed_value);
    int g;
    bit got;
    pooled_t r;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    pool_step(s, got, r);
    if (got) begin
      if (typed) r.value = typed_value;
      pending_pools.push_back(r);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(input logic [10:0] v [0:7]);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      pool_regs[i] = v[i] & ((11'd1 << (i == 0 ? 9 : i == 1 || i == 6 ? 11 :
                                        i == 7 ? 1 : 4)) - 11'd1);
      col_pos = 0; row_pos = 0; chan_pos = 0;
    end
    cfg_we <= 1'b0;
  endtask

  // output side: random stalls, calm stretches and one long hold-off
  initial begin
    int calm, stall, r;
    calm = 0; stall = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (calm > 0) begin
        out_ready <= 1'b1;
        calm--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 15) calm = $urandom_range(20, 100);
        else if (r < 92) stall = $urandom_range(0, 3);
        else stall = $urandom_range(10, 40);
        out_ready <= 1'b1;
      end
    end
  end

  // check every result transfer against the oldest expectation
  always @(posedge clk) begin
    pooled_t e, a;
    if (rst_n && out_valid && out_ready) begin
      a = '{out_pooled_value, out_offset_x, out_offset_y, out_col, out_row,
            out_channel, out_frame_last};
      if (pending_pools.size() == 0) begin
        $display("%0t unexpected result: %p", $time, a);
        errors++;
      end else begin
        e = pending_pools.pop_front();
        if (e !== a) begin
          $display("%0t mismatch: expected %p, actual %p", $time, e, a);
          errors++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("pool_2d_max_mean_top_tb: done, errors");
    $finish;
  end

  initial begin
    step_t steps [$];
    logic [10:0] v [0:7];
    int cur, items, n, r;
    bit held;
    logic signed [15:0] s;

    // max with a tie, mean at both extremes, truncation toward zero,
    // zero width with a window larger than the plane
    steps = '{
      '{0, 16'sd32767, 0, 0}, '{0, 16'sd0, 0, 0},
      '{0, 16'sd32767, 0, 0}, '{0, -16'sd32768, 1, 16'sd32767},
      '{1, -16'sd32768, 0, 0}, '{1, -16'sd32768, 0, 0},
      '{1, -16'sd32768, 0, 0}, '{1, -16'sd32768, 1, -16'sd32768},
      '{2, 16'sd32767, 0, 0}, '{2, 16'sd32767, 0, 0},
      '{2, 16'sd32767, 0, 0}, '{2, 16'sd32766, 1, 16'sd32766},
      '{3, -16'sd1, 0, 0}, '{3, -16'sd1, 0, 0},
      '{3, -16'sd1, 0, 0}, '{3, 16'sd0, 1, 16'sd0},
      '{4, 16'sd5, 0, 0}, '{4, -16'sd7, 0, 0}
    };

    pool_regs = '{RST_INPUT_WIDTH, RST_INPUT_HEIGHT, RST_WINDOW_WIDTH,
                  RST_WINDOW_HEIGHT, RST_X_STRIDE, RST_Y_STRIDE, RST_CHANNELS,
                  RST_POOL_MODE};
    col_pos = 0; row_pos = 0; chan_pos = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = -1;
    foreach (steps[i]) begin
      if (steps[i].phase != cur) begin
        cur = steps[i].phase;
        drain();
        case (cur)
          0: v = '{2, 2, 2, 2, 2, 2, 1, MODE_MAX};
          1, 2, 3: v = '{2, 2, 2, 2, 2, 2, 1, MODE_MEAN};
          default: v = '{0, 2, 2, 2, 0, 0, 0, MODE_MAX};
        endcase
        write_regs(v);
      end
      send_sample(steps[i].sample, steps[i].typed, steps[i].value);
    end

    items = 0;
    held = 0;
    while (items < 1500) begin
      drain();
      r = $urandom_range(0, 99);
      v[0] = r < 85 ? $urandom_range(1, 12) : r < 95 ? $urandom_range(0, 511) : 256;
      r = $urandom_range(0, 99);
      v[1] = r < 90 ? $urandom_range(1, 10) : $urandom_range(0, 2047);
      v[2] = $urandom_range(0, 99) < 85 ? $urandom_range(1, 4) : $urandom_range(0, 15);
      v[3] = $urandom_range(0, 99) < 85 ? $urandom_range(1, 4) : $urandom_range(0, 15);
      v[4] = $urandom_range(0, 99) < 85 ? $urandom_range(1, 3) : $urandom_range(0, 15);
      v[5] = $urandom_range(0, 99) < 85 ? $urandom_range(1, 3) : $urandom_range(0, 15);
      v[6] = $urandom_range(0, 99) < 90 ? $urandom_range(0, 3) : $urandom_range(0, 2047);
      v[7] = $urandom_range(0, 1);
      write_regs(v);
      n = eff(REG_INPUT_WIDTH, 256) * eff(REG_INPUT_HEIGHT, MAX_ROWS) *
          eff(REG_CHANNELS, MAX_CHANS);
      if (n > 200) n = $urandom_range(20, 150);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        s = r < 10 ? 16'sh7fff : r < 20 ? 16'sh8000 : r < 30 ? 16'sh0000 :
            16'($urandom);
        if (!held && items > 700) begin
          held = 1;
          hold_cycles = 400;
        end
        send_sample(s, 0, 0);
        items++;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("pool_2d_max_mean_top_tb: done, clean");
    end else begin
      $display("pool_2d_max_mean_top_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/pmm_pkg.sv
sv/pmm_line_store.sv
sv/pmm_div.sv
sv/pool_2d_max_mean_top.sv
sv/pmm_checker.sv
tb/pool_2d_max_mean_top_tb.sv
